// File: rtl/slik_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the symmetric
// leg inverse kinematics block. No dependencies.
package slik_pkg;

	// Configuration register indexes and reset values.
	localparam logic [1:0]  REG_FIRST_LINK  = 2'd0;
	localparam logic [1:0]  REG_OUTER_LINK  = 2'd1;
	localparam int          LINK_W          = 17;
	localparam logic [16:0] FIRST_LINK_RST  = 17'd15360;
	localparam logic [16:0] OUTER_LINK_RST  = 17'd30720;

	// Coordinate and angle widths.
	localparam int POS_W   = 18;
	localparam int ANGLE_W = 16;

	// CORDIC operand width at the input and datapath width inside.
	localparam int CIN_W = 19;
	localparam int CD_W  = 34;
	localparam int ATAN_ENTRIES = 24;

	// Quotient bits of the cosine divider below the saturation check.
	localparam int DIV_STEPS = 15;

	localparam logic signed [CD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef logic signed [CD_W-1:0] cword_t;

	// Truncated atan(2^-i) in Q.30 radians.
	function automatic cword_t atan_q30(input logic [4:0] idx);
		cword_t v;
		case (idx)
			5'd0:    v = 34'sd843314856;
			5'd1:    v = 34'sd497837829;
			5'd2:    v = 34'sd263043836;
			5'd3:    v = 34'sd133525158;
			5'd4:    v = 34'sd67021686;
			5'd5:    v = 34'sd33543515;
			5'd6:    v = 34'sd16775850;
			5'd7:    v = 34'sd8388437;
			5'd8:    v = 34'sd4194282;
			5'd9:    v = 34'sd2097149;
			5'd10:   v = 34'sd1048575;
			5'd11:   v = 34'sd524287;
			5'd12:   v = 34'sd262143;
			5'd13:   v = 34'sd131071;
			5'd14:   v = 34'sd65535;
			5'd15:   v = 34'sd32767;
			5'd16:   v = 34'sd16383;
			5'd17:   v = 34'sd8191;
			5'd18:   v = 34'sd4095;
			5'd19:   v = 34'sd2047;
			5'd20:   v = 34'sd1023;
			5'd21:   v = 34'sd511;
			5'd22:   v = 34'sd255;
			5'd23:   v = 34'sd127;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/slik_sqrt.sv
// Pipelined digit-by-digit integer square root, one result digit per stage.
// Carries a sideband payload alongside. No dependencies.
module slik_sqrt #(
	parameter int STEPS = 20,
	parameter int SW    = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [2*STEPS-1:0] in_value,
	input  logic [SW-1:0]      in_side,
	output logic               out_valid,
	output logic [STEPS-1:0]   out_root,
	output logic [SW-1:0]      out_side
);

	localparam int VW = 2*STEPS + 1;

	logic [VW-1:0] rem_s  [1:STEPS];
	logic [VW-1:0] res_s  [1:STEPS];
	logic [SW-1:0] side_s [1:STEPS];
	logic          vld_s  [1:STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [VW-1:0] BITC = {{(VW-1){1'b0}}, 1'b1} << (2*(STEPS-1-k));
		logic [VW-1:0] rem_c, res_c, trial;
		logic [SW-1:0] side_c;
		logic          vld_c;

		if (k == 0) begin : g_first
			assign rem_c  = {1'b0, in_value};
			assign res_c  = '0;
			assign side_c = in_side;
			assign vld_c  = in_valid;
		end else begin : g_next
			assign rem_c  = rem_s[k];
			assign res_c  = res_s[k];
			assign side_c = side_s[k];
			assign vld_c  = vld_s[k];
		end

		assign trial = res_c + BITC;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_c;
			if (rem_c >= trial) begin
				rem_s[k+1] <= rem_c - trial;
				res_s[k+1] <= (res_c >> 1) + BITC;
			end else begin
				rem_s[k+1] <= rem_c;
				res_s[k+1] <= res_c >> 1;
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign out_root  = res_s[STEPS][STEPS-1:0];
	assign out_side  = side_s[STEPS];

endmodule

// File: rtl/slik_cordic.sv
// Pipelined CORDIC vectoring unit that returns atan2(y, x) in Q.30 radians.
// Uses slik_pkg for the arctangent table and datapath widths.
module slik_cordic import slik_pkg::*; #(
	parameter int STEPS = 16,
	parameter int SW    = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [CIN_W-1:0] in_y,
	input  logic signed [CIN_W-1:0] in_x,
	input  logic [SW-1:0]           in_side,
	output logic                    out_valid,
	output cword_t                  out_angle,
	output logic [SW-1:0]           out_side
);

	cword_t        x_s    [0:STEPS];
	cword_t        y_s    [0:STEPS];
	cword_t        z_s    [0:STEPS];
	logic          zero_s [0:STEPS];
	logic [SW-1:0] side_s [0:STEPS];
	logic          vld_s  [0:STEPS];

	cword_t xs_c, ys_c;

	assign xs_c = CD_W'(in_x) <<< 12;
	assign ys_c = CD_W'(in_y) <<< 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	// Operands in the left half plane are turned by a quarter turn first.
	always_ff @(posedge clk) begin
		zero_s[0] <= (in_x == '0) && (in_y == '0);
		side_s[0] <= in_side;
		if (xs_c < 0) begin
			if (ys_c >= 0) begin
				x_s[0] <= ys_c;
				y_s[0] <= -xs_c;
				z_s[0] <= HALF_PI_Q30;
			end else begin
				x_s[0] <= -ys_c;
				y_s[0] <= xs_c;
				z_s[0] <= -HALF_PI_Q30;
			end
		end else begin
			x_s[0] <= xs_c;
			y_s[0] <= ys_c;
			z_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_iter
		cword_t dx, dy, ang;

		assign dx  = y_s[k] >>> k;
		assign dy  = x_s[k] >>> k;
		assign ang = atan_q30(5'(k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			zero_s[k+1] <= zero_s[k];
			side_s[k+1] <= side_s[k];
			if (y_s[k] >= 0) begin
				x_s[k+1] <= x_s[k] + dx;
				y_s[k+1] <= y_s[k] - dy;
				z_s[k+1] <= z_s[k] + ang;
			end else begin
				x_s[k+1] <= x_s[k] - dx;
				y_s[k+1] <= y_s[k] + dy;
				z_s[k+1] <= z_s[k] - ang;
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign out_angle = zero_s[STEPS] ? '0 : z_s[STEPS];
	assign out_side  = side_s[STEPS];

endmodule

// File: rtl/symmetric_leg_inverse_kinematics.sv
// Top level of the symmetric leg inverse kinematics pipeline.
// Depends on slik_pkg, slik_sqrt and slik_cordic.
//
// Usage:
// A request is taken at each rising edge with start high; busy is always low,
// so a new target point can be issued in every cycle. The link lengths are
// set through the cfg_valid/cfg_ready write channel (cfg_ready is always
// high); index 0 is the first link and index 1 the outer link, other
// indexes are ignored. Write them only while no request is in flight.
// Each result is shown for one cycle with done high. One result leaves per
// cycle at full rate; the rate is one point per cycle because every square
// root digit, divider bit and CORDIC step has its own pipeline stage. The
// receiver cannot stall, so the pipeline never holds. Reset clears all valid
// bits, so no spurious done is shown, and returns the link lengths to 15360
// and 30720.
module symmetric_leg_inverse_kinematics import slik_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [POS_W-1:0]   target_x,
	input  logic signed [POS_W-1:0]   target_y,
	output logic                      done,
	output logic signed [ANGLE_W-1:0] front_joint_angle,
	output logic signed [ANGLE_W-1:0] rear_joint_angle,
	output logic                      in_workspace,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [LINK_W-1:0]         cfg_data
);

	localparam int SQ1_STEPS = 20;
	localparam int SQ2_STEPS = 16;
	localparam int SW1 = 2 + LINK_W + 38 + 2*POS_W;
	localparam int SW2 = 2 + ANGLE_W + 2*POS_W;

	function automatic logic signed [ANGLE_W-1:0] sat_q12(input logic signed [34:0] v);
		logic signed [34:0] r;
		logic signed [16:0] q;
		r = v + 35'sd131072;
		q = 17'(r >>> 18);
		if (q > 17'sd32767) begin
			return 16'sh7fff;
		end else if (q < -17'sd32768) begin
			return 16'sh8000;
		end
		return q[15:0];
	endfunction

	logic [LINK_W-1:0] first_link_q, outer_link_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_link_q <= FIRST_LINK_RST;
			outer_link_q <= OUTER_LINK_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIRST_LINK: first_link_q <= cfg_data;
				REG_OUTER_LINK: outer_link_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stages 1 to 4: squares, distance squared, cosine numerator, reach test.
	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [POS_W-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic [LINK_W-1:0]       a_s1, b_s1, a_s2, a_s3, a_s4;
	logic [35:0]             xx_s2, yy_s2, d2_s3, maxr2_s3, d2_s4;
	logic [33:0]             aa_s2, bb_s2, minr2_s3;
	logic [16:0]             minr_s2;
	logic [17:0]             maxr_s2;
	logic                    zero_s2, bz_s3, bz_s4, inside_s4;
	logic signed [37:0]      num_s3, num_s4;
	logic signed [35:0]      xx_w, yy_w;

	assign xx_w = x_s1 * x_s1;
	assign yy_w = y_s1 * y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= target_x;
		y_s1 <= target_y;
		a_s1 <= first_link_q;
		b_s1 <= outer_link_q;

		xx_s2   <= $unsigned(xx_w);
		yy_s2   <= $unsigned(yy_w);
		aa_s2   <= a_s1 * a_s1;
		bb_s2   <= b_s1 * b_s1;
		minr_s2 <= (a_s1 > b_s1) ? a_s1 - b_s1 : b_s1 - a_s1;
		maxr_s2 <= {1'b0, a_s1} + {1'b0, b_s1};
		zero_s2 <= (x_s1 == '0) && (y_s1 == '0);
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		a_s2    <= a_s1;

		d2_s3    <= xx_s2 + yy_s2;
		num_s3   <= $signed({4'b0, aa_s2}) + $signed({2'b0, xx_s2 + yy_s2})
			- $signed({4'b0, bb_s2});
		minr2_s3 <= minr_s2 * minr_s2;
		maxr2_s3 <= maxr_s2 * maxr_s2;
		bz_s3    <= zero_s2 || (a_s2 == '0);
		x_s3     <= x_s2;
		y_s3     <= y_s2;
		a_s3     <= a_s2;

		inside_s4 <= (d2_s3 >= {2'b0, minr2_s3}) && (d2_s3 <= maxr2_s3);
		d2_s4     <= d2_s3;
		num_s4    <= num_s3;
		bz_s4     <= bz_s3;
		x_s4      <= x_s3;
		y_s4      <= y_s3;
		a_s4      <= a_s3;
	end

	// Distance L = round(sqrt(d2)), taken as floor(sqrt(4*d2)) halved.
	logic                   sq1_valid;
	logic [SQ1_STEPS-1:0]   sq1_root;
	logic [SW1-1:0]         sq1_side;

	slik_sqrt #(.STEPS(SQ1_STEPS), .SW(SW1)) u_sqrt_len (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_value  ({2'b0, d2_s4, 2'b0}),
		.in_side   ({inside_s4, bz_s4, a_s4, num_s4, x_s4, y_s4}),
		.out_valid (sq1_valid),
		.out_root  (sq1_root),
		.out_side  (sq1_side)
	);

	logic                    q1_inside, q1_bz;
	logic [LINK_W-1:0]       q1_a;
	logic signed [37:0]      q1_num;
	logic signed [POS_W-1:0] q1_x, q1_y;
	logic [SQ1_STEPS:0]      root1_inc;

	assign {q1_inside, q1_bz, q1_a, q1_num, q1_x, q1_y} = sq1_side;
	assign root1_inc = {1'b0, sq1_root} + 1'b1;

	// Stages 5 to 7: denominator 2*A*L and the rounded divider dividend.
	logic                    vld_s5, vld_s6, vld_s7;
	logic [17:0]             len_s5;
	logic [36:0]             mag_s5, mag_s6;
	logic [LINK_W-1:0]       a_s5;
	logic                    neg_s5, neg_s6, neg_s7;
	logic                    ins_s5, ins_s6, ins_s7, bz_s5, bz_s6, bz_s7;
	logic signed [POS_W-1:0] x_s5, y_s5, x_s6, y_s6, x_s7, y_s7;
	logic [35:0]             den_s6, den_s7;
	logic [51:0]             n_s7;
	logic [34:0]             al_w;

	assign al_w = a_s5 * len_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s5 <= sq1_valid;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		len_s5 <= root1_inc[18:1];
		mag_s5 <= q1_num[37] ? 37'(-q1_num) : q1_num[36:0];
		neg_s5 <= q1_num[37];
		a_s5   <= q1_a;
		ins_s5 <= q1_inside;
		bz_s5  <= q1_bz;
		x_s5   <= q1_x;
		y_s5   <= q1_y;

		den_s6 <= {al_w, 1'b0};
		mag_s6 <= mag_s5;
		neg_s6 <= neg_s5;
		ins_s6 <= ins_s5;
		bz_s6  <= bz_s5;
		x_s6   <= x_s5;
		y_s6   <= y_s5;

		n_s7   <= {1'b0, mag_s6, 14'b0} + {17'b0, den_s6[35:1]};
		den_s7 <= den_s6;
		neg_s7 <= neg_s6;
		ins_s7 <= ins_s6;
		bz_s7  <= bz_s6;
		x_s7   <= x_s6;
		y_s7   <= y_s6;
	end

	// Restoring divider: element 0 holds the saturation check, then one
	// quotient bit per stage from the top.
	logic                    dv_s   [0:DIV_STEPS];
	logic [51:0]             drem_s [0:DIV_STEPS];
	logic [DIV_STEPS-1:0]    dq_s   [0:DIV_STEPS];
	logic [35:0]             dden_s [0:DIV_STEPS];
	logic                    dsat_s [0:DIV_STEPS];
	logic                    dneg_s [0:DIV_STEPS];
	logic                    dins_s [0:DIV_STEPS];
	logic                    dbz_s  [0:DIV_STEPS];
	logic signed [POS_W-1:0] dx_s   [0:DIV_STEPS];
	logic signed [POS_W-1:0] dy_s   [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else begin
			dv_s[0] <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		dsat_s[0] <= n_s7 >= {1'b0, den_s7, 15'b0};
		drem_s[0] <= n_s7;
		dq_s[0]   <= '0;
		dden_s[0] <= den_s7;
		dneg_s[0] <= neg_s7;
		dins_s[0] <= ins_s7;
		dbz_s[0]  <= bz_s7;
		dx_s[0]   <= x_s7;
		dy_s[0]   <= y_s7;
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int BITI = DIV_STEPS - 1 - k;
		logic [51:0] trial;

		assign trial = {16'b0, dden_s[k]} << BITI;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= 1'b0;
			end else begin
				dv_s[k+1] <= dv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dden_s[k+1] <= dden_s[k];
			dsat_s[k+1] <= dsat_s[k];
			dneg_s[k+1] <= dneg_s[k];
			dins_s[k+1] <= dins_s[k];
			dbz_s[k+1]  <= dbz_s[k];
			dx_s[k+1]   <= dx_s[k];
			dy_s[k+1]   <= dy_s[k];
			if (drem_s[k] >= trial) begin
				drem_s[k+1] <= drem_s[k] - trial;
				dq_s[k+1]   <= dq_s[k] | (DIV_STEPS'(1) << BITI);
			end else begin
				drem_s[k+1] <= drem_s[k];
				dq_s[k+1]   <= dq_s[k];
			end
		end
	end

	// Stages 9 to 11: clamped cosine c, then 2^28 - c*c for the sine root.
	logic                    vld_s9, vld_s10, vld_s11;
	logic signed [15:0]      c_s9, c_s10, c_s11;
	logic [28:0]             cc_s10, v_s11;
	logic                    ins_s9, ins_s10, ins_s11, bz_s9, bz_s10, bz_s11;
	logic signed [POS_W-1:0] x_s9, y_s9, x_s10, y_s10, x_s11, y_s11;
	logic [15:0]             qc_w;
	logic signed [31:0]      cc_w;

	assign qc_w = (dsat_s[DIV_STEPS] || (dq_s[DIV_STEPS] > 15'd16384))
		? 16'd16384 : {1'b0, dq_s[DIV_STEPS]};
	assign cc_w = c_s9 * c_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s9  <= dv_s[DIV_STEPS];
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		c_s9   <= dneg_s[DIV_STEPS] ? -$signed(qc_w) : $signed(qc_w);
		ins_s9 <= dins_s[DIV_STEPS];
		bz_s9  <= dbz_s[DIV_STEPS];
		x_s9   <= dx_s[DIV_STEPS];
		y_s9   <= dy_s[DIV_STEPS];

		cc_s10  <= cc_w[28:0];
		c_s10   <= c_s9;
		ins_s10 <= ins_s9;
		bz_s10  <= bz_s9;
		x_s10   <= x_s9;
		y_s10   <= y_s9;

		v_s11   <= 29'd268435456 - cc_s10;
		c_s11   <= c_s10;
		ins_s11 <= ins_s10;
		bz_s11  <= bz_s10;
		x_s11   <= x_s10;
		y_s11   <= y_s10;
	end

	logic                 sq2_valid;
	logic [SQ2_STEPS-1:0] sq2_root;
	logic [SW2-1:0]       sq2_side;

	slik_sqrt #(.STEPS(SQ2_STEPS), .SW(SW2)) u_sqrt_sin (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s11),
		.in_value  ({1'b0, v_s11, 2'b0}),
		.in_side   ({ins_s11, bz_s11, c_s11, x_s11, y_s11}),
		.out_valid (sq2_valid),
		.out_root  (sq2_root),
		.out_side  (sq2_side)
	);

	logic                    q2_inside, q2_bz;
	logic signed [15:0]      q2_c;
	logic signed [POS_W-1:0] q2_x, q2_y;
	logic [SQ2_STEPS:0]      root2_inc;

	assign {q2_inside, q2_bz, q2_c, q2_x, q2_y} = sq2_side;
	assign root2_inc = {1'b0, sq2_root} + 1'b1;

	// Stage 12 feeds both arctangent units side by side.
	logic                    vld_s12, ins_s12, bz_s12;
	logic [15:0]             s_s12;
	logic signed [15:0]      c_s12;
	logic signed [POS_W-1:0] x_s12, y_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else begin
			vld_s12 <= sq2_valid;
		end
	end

	always_ff @(posedge clk) begin
		s_s12   <= root2_inc[16:1];
		c_s12   <= q2_c;
		ins_s12 <= q2_inside;
		bz_s12  <= q2_bz;
		x_s12   <= q2_x;
		y_s12   <= q2_y;
	end

	logic   alpha_valid, beta_valid, alpha_inside, beta_zero;
	cword_t alpha_ang, beta_ang, beta_sel;

	slik_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_cordic_alpha (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s12),
		.in_y      (CIN_W'(y_s12)),
		.in_x      (CIN_W'(x_s12)),
		.in_side   (ins_s12),
		.out_valid (alpha_valid),
		.out_angle (alpha_ang),
		.out_side  (alpha_inside)
	);

	slik_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_cordic_beta (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s12),
		.in_y      ($signed({3'b0, s_s12})),
		.in_x      (CIN_W'(c_s12)),
		.in_side   (bz_s12),
		.out_valid (beta_valid),
		.out_angle (beta_ang),
		.out_side  (beta_zero)
	);

	assign beta_sel = beta_zero ? '0 : beta_ang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= alpha_valid && beta_valid;
		end
	end

	always_ff @(posedge clk) begin
		front_joint_angle <= sat_q12(35'(alpha_ang) + 35'(beta_sel));
		rear_joint_angle  <= sat_q12(35'(alpha_ang) - 35'(beta_sel));
		in_workspace      <= alpha_inside;
	end

endmodule

// File: verif/slik_checker.sv
// Scoreboard for the leg inverse kinematics block: it watches requests, link
// writes and results, predicts the joint angles and compares them in order.
// Depends on slik_pkg for widths and register indexes.
module slik_checker import slik_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic signed [POS_W-1:0]   target_x,
	input  logic signed [POS_W-1:0]   target_y,
	input  logic                      done,
	input  logic signed [ANGLE_W-1:0] front_joint_angle,
	input  logic signed [ANGLE_W-1:0] rear_joint_angle,
	input  logic                      in_workspace,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [LINK_W-1:0]         cfg_data,
	output int                        errors,
	output int                        pending,
	output int                        checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [ANGLE_W-1:0] front;
		logic signed [ANGLE_W-1:0] rear;
		logic                      reach;
	} joint_angles_t;

	localparam longint QUARTER_TURN = 64'sd1686629713;

	longint arctan_steps [24] = '{
		843314856, 497837829, 263043836, 133525158,
		67021686, 33543515, 16775850, 8388437,
		4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767,
		16383, 8191, 4095, 2047,
		1023, 511, 255, 127
	};

	logic [LINK_W-1:0] first_link;
	logic [LINK_W-1:0] outer_link;
	joint_angles_t     angle_queue[$];

	function automatic longint root_nearest(input longint v);
		longint rem, res, b;
		rem = v << 2;
		res = 0;
		b = 64'sd1 << 38;
		for (int k = 0; k < 20; k++) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return (res + 1) >> 1;
	endfunction

	function automatic longint bearing(input longint yi, input longint xi);
		longint x, y, z, t, dx, dy;
		if (xi == 0 && yi == 0)
			return 0;
		x = xi * 4096;
		y = yi * 4096;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = QUARTER_TURN;
			end else begin
				t = x; x = -y; y = t; z = -QUARTER_TURN;
			end
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += arctan_steps[i];
			end else begin
				x -= dx; y += dy; z -= arctan_steps[i];
			end
		end
		return z;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] angle_q12(input longint q30);
		longint v;
		v = (q30 + (64'sd1 << 17)) >>> 18;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[ANGLE_W-1:0];
	endfunction

	function automatic joint_angles_t solve_leg(input longint x, input longint y,
			input longint a, input longint b);
		joint_angles_t r;
		longint d2, alpha, beta, minr, maxr, len, num, den, mag, q, c, s;
		d2 = x * x + y * y;
		alpha = 0;
		beta = 0;
		minr = (a > b) ? a - b : b - a;
		maxr = a + b;
		if (d2 != 0) begin
			len = root_nearest(d2);
			num = a * a + d2 - b * b;
			den = 2 * a * len;
			alpha = bearing(y, x);
			if (den > 0) begin
				mag = (num < 0) ? -num : num;
				q = (mag * 16384 + den / 2) / den;
				if (q > 16384)
					q = 16384;
				c = (num < 0) ? -q : q;
				s = root_nearest((64'sd1 << 28) - c * c);
				beta = bearing(s, c);
			end
		end
		r.front = angle_q12(alpha + beta);
		r.rear = angle_q12(alpha - beta);
		r.reach = (d2 >= minr * minr) && (d2 <= maxr * maxr);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		joint_angles_t exp_r;
		if (!arst_n) begin
			first_link <= FIRST_LINK_RST;
			outer_link <= OUTER_LINK_RST;
			angle_queue.delete();
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (done) begin
				if (angle_queue.size() == 0) begin
					$display("%0t: result with no request waiting: front %0d rear %0d reach %0b",
						$time, front_joint_angle, rear_joint_angle, in_workspace);
					errors <= errors + 1;
				end else begin
					exp_r = angle_queue.pop_front();
					checked <= checked + 1;
					if (exp_r.front !== front_joint_angle || exp_r.rear !== rear_joint_angle ||
							exp_r.reach !== in_workspace) begin
						$display("%0t: mismatch: expected front %0d rear %0d reach %0b, got %0d %0d %0b",
							$time, exp_r.front, exp_r.rear, exp_r.reach,
							front_joint_angle, rear_joint_angle, in_workspace);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				angle_queue.push_back(solve_leg(target_x, target_y, first_link, outer_link));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FIRST_LINK)
					first_link <= cfg_data;
				else if (cfg_index == REG_OUTER_LINK)
					outer_link <= cfg_data;
			end
			pending <= angle_queue.size();
		end
	end

endmodule

// File: verif/tb.sv
// Top of the leg inverse kinematics testbench: clock, reset, link writes and
// target points with random bursts. Depends on slik_pkg, slik_checker and the block.
module tb import slik_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 4000;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [POS_W-1:0]   target_x;
	logic signed [POS_W-1:0]   target_y;
	logic                      done;
	logic signed [ANGLE_W-1:0] front_joint_angle;
	logic signed [ANGLE_W-1:0] rear_joint_angle;
	logic                      in_workspace;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [1:0]                cfg_index;
	logic [LINK_W-1:0]         cfg_data;
	int                        errors;
	int                        pending;
	int                        checked;
	int                        points_sent;
	int                        burst_left;
	int                        idle_cycles;
	int                        cur_first;
	int                        cur_outer;

	symmetric_leg_inverse_kinematics dut (.*);

	slik_checker scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Any accepted request, result or link write counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout at %0t with %0d results outstanding", $time, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_point(input int x, input int y);
		@(negedge clk);
		start <= 1'b1;
		target_x <= x[POS_W-1:0];
		target_y <= y[POS_W-1:0];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		points_sent++;
		// Bursts of back-to-back requests separated by random gaps.
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat ($urandom_range(0, 12))
					@(negedge clk);
			end
		end
	endtask

	task automatic quiesce();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_link(input logic [1:0] idx, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[LINK_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_FIRST_LINK)
			cur_first = value & 32'h1FFFF;
		else if (idx == REG_OUTER_LINK)
			cur_outer = value & 32'h1FFFF;
	endtask

	function automatic int clip_pos(input int v);
		if (v > 131071)
			return 131071;
		if (v < -131072)
			return -131072;
		return v;
	endfunction

	task automatic random_points(input int count);
		int reach, x, y;
		reach = cur_first + cur_outer;
		if (reach > 131071)
			reach = 131071;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					x = $signed($urandom_range(0, 262143) - 131072);
					y = $signed($urandom_range(0, 262143) - 131072);
				end
				3: begin
					x = $urandom_range(0, 1024) - 512;
					y = $urandom_range(0, 1024) - 512;
				end
				default: begin
					// Points scaled to the current links reach the law of cosines.
					x = $urandom_range(0, 2 * reach) - reach;
					y = $urandom_range(0, 2 * reach) - reach;
				end
			endcase
			send_point(clip_pos(x), clip_pos(y));
		end
	endtask

	task automatic boundary_points();
		int lo, hi;
		lo = (cur_first > cur_outer) ? cur_first - cur_outer : cur_outer - cur_first;
		hi = cur_first + cur_outer;
		send_point(clip_pos(hi), 0);
		send_point(clip_pos(hi + 1), 0);
		send_point(0, clip_pos(lo));
		send_point(0, clip_pos(lo - 1));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		target_x = '0;
		target_y = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FIRST_LINK;
		cfg_data = '0;
		idle_cycles = 0;
		points_sent = 0;
		burst_left = 8;
		cur_first = FIRST_LINK_RST;
		cur_outer = OUTER_LINK_RST;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed points at the reset link lengths: origin, corners, axes,
		// every quadrant, the reach limits.
		send_point(0, 0);
		send_point(131071, 131071);
		send_point(-131072, -131072);
		send_point(-131072, 131071);
		send_point(131071, -131072);
		send_point(-5000, 0);
		send_point(-5000, -1);
		send_point(0, 7000);
		send_point(0, -7000);
		send_point(1, 0);
		send_point(-1, 0);
		send_point(20000, 25000);
		boundary_points();
		random_points(60);
		quiesce();

		// Smallest nonzero links, with writes to the unused indexes that must be ignored.
		write_link(REG_FIRST_LINK, 1);
		write_link(REG_OUTER_LINK, 1);
		write_link(2'd2, $urandom_range(0, 131071));
		write_link(2'd3, $urandom_range(0, 131071));
		send_point(1, 0);
		send_point(0, 2);
		send_point(0, 0);
		random_points(50);
		quiesce();

		// Largest links.
		write_link(REG_FIRST_LINK, 131071);
		write_link(REG_OUTER_LINK, 131071);
		boundary_points();
		random_points(60);
		quiesce();

		// A first link of zero has no cosine.
		write_link(REG_FIRST_LINK, 0);
		write_link(REG_OUTER_LINK, 20000);
		boundary_points();
		random_points(50);
		quiesce();

		// Very unequal links in both directions.
		write_link(REG_FIRST_LINK, 131071);
		write_link(REG_OUTER_LINK, 1);
		boundary_points();
		random_points(50);
		quiesce();
		write_link(REG_FIRST_LINK, 300);
		write_link(REG_OUTER_LINK, 90000);
		boundary_points();
		random_points(50);
		quiesce();

		for (int phase = 0; phase < 3; phase++) begin
			write_link(REG_FIRST_LINK, $urandom_range(1, 70000));
			write_link(REG_OUTER_LINK, $urandom_range(1, 70000));
			random_points(35);
			quiesce();
		end

		$display("Sent %0d target points over nine link settings, %0d results checked.",
			points_sent, checked);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
rtl/slik_pkg.sv
rtl/slik_sqrt.sv
rtl/slik_cordic.sv
rtl/symmetric_leg_inverse_kinematics.sv
verif/slik_checker.sv
verif/tb.sv
